@@ rtl/deq_pkg.sv @@
// shared types and constants of the double-ended queue
package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int ST_W      = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic write;
    logic read;
    logic load;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_push;
    logic is_read;
    logic full;
    logic empty;
  } sts_t;

endpackage

@@ rtl/deq_ram.sv @@
// generic single-port ram with registered read
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/deq_ctrl.sv @@
// controller state machine of the double-ended queue
module deq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  deq_pkg::sts_t sts,
  output deq_pkg::ctl_t ctl
);

  import deq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = (sts.is_read && !sts.empty) ? S_LOAD : S_DONE;
      end
      S_LOAD: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        ctl.capture = in_tvalid;
      end
      S_EXEC: begin
        ctl.exec  = 1'b1;
        ctl.write = sts.is_push && !sts.full;
        ctl.read  = sts.is_read && !sts.empty;
      end
      S_LOAD: begin
        ctl.load = 1'b1;
      end
      S_DONE: begin
        out_tvalid = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

@@ rtl/deq_dp.sv @@
// datapath of the double-ended queue: ring pointers, store and result registers
module deq_dp #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [deq_pkg::CMD_W-1:0]           cmd,
  input  logic signed [deq_pkg::DATA_W-1:0]   value,
  input  deq_pkg::ctl_t                       ctl,
  output deq_pkg::sts_t                       sts,
  output logic signed [deq_pkg::DATA_W-1:0]   result_value,
  output logic [deq_pkg::ST_W-1:0]            status,
  output logic [$clog2(DEPTH+1)-1:0]          fill_level
);

  import deq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  logic [CMD_W-1:0]         cmd_r;
  logic signed [DATA_W-1:0] value_r;
  logic [IW-1:0]            front_r;
  logic [CW-1:0]            count_r;
  logic signed [DATA_W-1:0] res_r;
  logic [ST_W-1:0]          status_r;

  logic [IW-1:0]            front_inc;
  logic [IW-1:0]            front_dec;
  logic [SW-1:0]            tail_sum;
  logic [SW-1:0]            last_sum;
  logic [IW-1:0]            tail_idx;
  logic [IW-1:0]            last_idx;
  logic [IW-1:0]            slot;
  logic [DATA_W-1:0]        rdata;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r   <= cmd;
      value_r <= value;
    end
  end

  assign sts.is_push = (cmd_r == CMD_PUSH_FRONT) || (cmd_r == CMD_PUSH_BACK);
  assign sts.is_read = (cmd_r == CMD_POP_FRONT) || (cmd_r == CMD_POP_BACK) ||
                       (cmd_r == CMD_PEEK_FRONT) || (cmd_r == CMD_PEEK_BACK);
  assign sts.full    = (count_r == DEPTH_C);
  assign sts.empty   = (count_r == '0);

  // ring arithmetic, front below depth and count at most depth, so one subtract wraps
  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
  assign tail_sum  = SW'(front_r) + SW'(count_r);
  assign last_sum  = tail_sum - 1'b1;
  assign tail_idx  = (tail_sum >= DEPTH_S) ? IW'(tail_sum - DEPTH_S) : IW'(tail_sum);
  assign last_idx  = (last_sum >= DEPTH_S) ? IW'(last_sum - DEPTH_S) : IW'(last_sum);

  always_comb begin
    case (cmd_r)
      CMD_PUSH_FRONT: slot = front_dec;
      CMD_PUSH_BACK:  slot = tail_idx;
      CMD_POP_BACK,
      CMD_PEEK_BACK:  slot = last_idx;
      default:        slot = front_r;
    endcase
  end

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.write),
    .re    (ctl.read),
    .addr  (slot),
    .wdata (value_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      count_r  <= '0;
      status_r <= ST_OK;
    end else if (ctl.exec) begin
      if (sts.is_push && sts.full) begin
        status_r <= ST_FULL;
      end else if (sts.is_read && sts.empty) begin
        status_r <= ST_EMPTY;
      end else begin
        status_r <= ST_OK;
      end
      if (ctl.write) begin
        count_r <= count_r + 1'b1;
        if (cmd_r == CMD_PUSH_FRONT) front_r <= front_dec;
      end
      if (ctl.read) begin
        if (cmd_r == CMD_POP_FRONT) begin
          front_r <= front_inc;
          count_r <= count_r - 1'b1;
        end else if (cmd_r == CMD_POP_BACK) begin
          count_r <= count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      res_r <= '0;
    end else if (ctl.load) begin
      res_r <= rdata;
    end
  end

  assign result_value = res_r;
  assign status       = status_r;
  assign fill_level   = count_r;

endmodule

@@ rtl/double_ended_queue_top.sv @@
// top level of the double-ended queue
// Signed 32-bit double-ended queue on a ring of DEPTH words. One command per
// input transfer, one result per command. The block handles one command at a
// time: a command that reads the store (pop or peek with data present) passes
// from the execute state through a load state to the result state, any other
// command goes from execute straight to result, and the result then waits for
// out_tready. The next input transfer can come in the cycle after the result
// transfer. The load state of a read serves the registered read port of the
// store ram. Pushes when full and pops or peeks when empty report an error
// status and leave the queue unchanged.
module double_ended_queue_top #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  input  logic [deq_pkg::DATA_W-1:0]                in_tdata,   // value
  input  logic [deq_pkg::CMD_W-1:0]                 in_tuser,   // cmd
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output logic [((deq_pkg::DATA_W+$clog2(DEPTH+1)+7)/8)*8-1:0]
                                                    out_tdata,  // result_value, fill_level
  output logic [deq_pkg::ST_W-1:0]                  out_tuser   // status
);

  import deq_pkg::*;

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int TDW = ((DATA_W + CW + 7) / 8) * 8;

  ctl_t                     ctl;
  sts_t                     sts;
  logic signed [DATA_W-1:0] result_value;
  logic [CW-1:0]            fill_level;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .ctl        (ctl)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (in_tuser),
    .value        (in_tdata),
    .ctl          (ctl),
    .sts          (sts),
    .result_value (result_value),
    .status       (out_tuser),
    .fill_level   (fill_level)
  );

  assign out_tdata = TDW'({fill_level, result_value});

endmodule

@@ rtl/deq_checker.sv @@
// port-level checks of the double-ended queue, bound to the top level
module deq_checker #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input logic                                                clk,
  input logic                                                rst_n,
  input logic                                                in_tvalid,
  input logic                                                in_tready,
  input logic [deq_pkg::DATA_W-1:0]                          in_tdata,
  input logic [deq_pkg::CMD_W-1:0]                           in_tuser,
  input logic                                                out_tvalid,
  input logic                                                out_tready,
  input logic [((deq_pkg::DATA_W+$clog2(DEPTH+1)+7)/8)*8-1:0] out_tdata,
  input logic [deq_pkg::ST_W-1:0]                            out_tuser
);

  import deq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] res;
  logic [CW-1:0]     fill;

  assign res  = out_tdata[DATA_W-1:0];
  assign fill = out_tdata[DATA_W+CW-1:DATA_W];

  // one command in flight: no new transfer right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a command is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

  a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_EMPTY) |-> (fill == '0 && res == '0))
    else $error("empty error with data present");

  a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_FULL) |-> (fill == CW'(DEPTH) && res == '0))
    else $error("full error while not full");

endmodule

bind double_ended_queue_top deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);
